>>> hw/rtl/pit_pkg.sv
// package: constants, codes and types shared by the periodic interrupt timer
package pit_pkg;

  localparam int PIT_COUNTER_WIDTH  = 32;
  localparam int PIT_PRESCALE_WIDTH = 12;

  localparam int CTRL_WIDTH = 26;
  localparam int DATA_WIDTH = 32;

  // control register bit positions
  localparam int CTRL_EN   = 0;
  localparam int ENMOD     = 1;
  localparam int OCIEN     = 2;
  localparam int RLD       = 3;
  localparam int PRESCALER = 4;
  localparam int IOVW      = 17;
  localparam int CLKSRC    = 24;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } pit_mode_t;

  typedef enum logic [2:0] {
    REG_CONTROL = 3'd0,
    REG_STATUS  = 3'd1,
    REG_LOAD    = 3'd2,
    REG_COMPARE = 3'd3,
    REG_COUNTER = 3'd4
  } pit_reg_t;

  // one bus beat or tick as it travels from the input stage to the register file
  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } pit_cmd_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq;
  } pit_result_t;

endpackage

>>> hw/rtl/pit_regs.sv
// register file and counter update logic of the periodic interrupt timer
module pit_regs
  import pit_pkg::*;
#(
  parameter int COUNTER_WIDTH  = PIT_COUNTER_WIDTH,
  parameter int PRESCALE_WIDTH = PIT_PRESCALE_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  pit_cmd_t    cmd,
  output pit_result_t result
);

  logic [CTRL_WIDTH-1:0]     control_bits, control_bits_next;
  logic                      compare_flag, compare_flag_next;
  logic [COUNTER_WIDTH-1:0]  load_value, load_value_next;
  logic [COUNTER_WIDTH-1:0]  compare_value, compare_value_next;
  logic [COUNTER_WIDTH-1:0]  count_value, count_value_next;
  logic [PRESCALE_WIDTH-1:0] prescale_count, prescale_count_next;

  logic [COUNTER_WIDTH-1:0]  data_masked;
  logic [CTRL_WIDTH-1:0]     ctrl_new;
  logic [PRESCALE_WIDTH-1:0] limit;
  logic [COUNTER_WIDTH-1:0]  count_step;
  logic [DATA_WIDTH-1:0]     read_value;
  logic                      tick_live;

  assign data_masked = COUNTER_WIDTH'(cmd.write_data);
  assign ctrl_new    = cmd.write_data[CTRL_WIDTH-1:0];
  assign limit       = control_bits[PRESCALER +: PRESCALE_WIDTH];
  assign tick_live   = control_bits[CTRL_EN] && (control_bits[CLKSRC +: 2] != 2'b00);

  // down count with reload or wrap to all ones at zero
  always_comb begin
    if (count_value == '0) begin
      count_step = control_bits[RLD] ? load_value : '1;
    end else begin
      count_step = count_value - COUNTER_WIDTH'(1);
    end
  end

  always_comb begin
    control_bits_next   = control_bits;
    compare_flag_next   = compare_flag;
    load_value_next     = load_value;
    compare_value_next  = compare_value;
    count_value_next    = count_value;
    prescale_count_next = prescale_count;
    read_value          = '0;
    case (cmd.mode)
      MODE_TICK: begin
        if (tick_live) begin
          if (prescale_count < limit) begin
            prescale_count_next = prescale_count + PRESCALE_WIDTH'(1);
          end else begin
            prescale_count_next = '0;
            count_value_next    = count_step;
            if (count_step == compare_value) begin
              compare_flag_next = 1'b1;
            end
          end
        end
      end
      MODE_READ: begin
        unique case (cmd.reg_index)
          REG_CONTROL: read_value = DATA_WIDTH'(control_bits);
          REG_STATUS:  read_value = DATA_WIDTH'(compare_flag);
          REG_LOAD:    read_value = DATA_WIDTH'(load_value);
          REG_COMPARE: read_value = DATA_WIDTH'(compare_value);
          REG_COUNTER: read_value = DATA_WIDTH'(count_value);
          default:     read_value = '0;
        endcase
      end
      MODE_WRITE: begin
        unique case (cmd.reg_index)
          REG_CONTROL: begin
            // restart on a rising enable when enable mode is set
            if (!control_bits[CTRL_EN] && ctrl_new[CTRL_EN] && ctrl_new[ENMOD]) begin
              count_value_next    = ctrl_new[RLD] ? load_value : '1;
              prescale_count_next = '0;
            end
            control_bits_next = ctrl_new;
          end
          REG_STATUS: begin
            if (cmd.write_data[0]) begin
              compare_flag_next = 1'b0;
            end
          end
          REG_LOAD: begin
            load_value_next = data_masked;
            if (control_bits[IOVW]) begin
              count_value_next = data_masked;
            end
          end
          REG_COMPARE: compare_value_next = data_masked;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result = {read_value, compare_flag_next && control_bits_next[OCIEN]};

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits   <= '0;
      compare_flag   <= 1'b0;
      load_value     <= '1;
      compare_value  <= '0;
      count_value    <= '1;
      prescale_count <= '0;
    end else if (step) begin
      control_bits   <= control_bits_next;
      compare_flag   <= compare_flag_next;
      load_value     <= load_value_next;
      compare_value  <= compare_value_next;
      count_value    <= count_value_next;
      prescale_count <= prescale_count_next;
    end
  end

endmodule

>>> hw/rtl/periodic_interrupt_timer_core.sv
// Periodic interrupt timer core: each input beat is one timer clock tick or one
// bus read or write of the control, status, load, compare or counter register,
// and each gives exactly one result beat carrying read data (zero for ticks and
// writes) and the interrupt line after that beat. One beat is accepted every
// cycle while the output register is empty or its result is taken; a beat is
// held in the input register until it moves on, when the register file takes
// its update and its result is loaded into the output register. The output
// register lets a new beat enter while a result is still waiting to be taken.
module periodic_interrupt_timer_core
  import pit_pkg::*;
#(
  parameter int COUNTER_WIDTH  = PIT_COUNTER_WIDTH,
  parameter int PRESCALE_WIDTH = PIT_PRESCALE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [2:0]            reg_index,
  input  logic [DATA_WIDTH-1:0] write_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic                  irq
);

  logic        s1_valid;
  pit_cmd_t    s1_cmd;
  logic        advance;
  pit_result_t result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd.mode       <= mode;
      s1_cmd.reg_index  <= reg_index;
      s1_cmd.write_data <= write_data;
    end
  end

  pit_regs #(
    .COUNTER_WIDTH  (COUNTER_WIDTH),
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cmd    (s1_cmd),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= result.read_data;
      irq       <= result.irq;
    end
  end

endmodule
